@@ rtl/ttc_pkg.sv @@
// shared constants, codes and types of the text terminal cursor engine
package ttc_pkg;

    // screen geometry and default attribute
    localparam int ROWS         = 25;
    localparam int COLS         = 80;
    localparam int DEFAULT_ATTR = 15;

    localparam int CELLS  = ROWS * COLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = 16;

    localparam logic [7:0] ROWS_B     = 8'(ROWS);
    localparam logic [7:0] COLS_B     = 8'(COLS);
    localparam logic [7:0] DEF_ATTR_B = 8'(DEFAULT_ATTR);

    // control characters
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // operation codes
    typedef enum logic [2:0] {
        FN_PUT   = 3'd0,
        FN_WRITE = 3'd1,
        FN_SETCUR = 3'd2,
        FN_CLEAR = 3'd3,
        FN_ATTR  = 3'd4,
        FN_READ  = 3'd5
    } func_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR,
        ST_POS,
        ST_FINISH
    } state_t;

    // one input word, unpacked
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] char_code;
        logic [7:0] row_sel;
        logic [7:0] col_sel;
        logic [7:0] attr;
    } item_t;

    // one result word, unpacked
    typedef struct packed {
        logic [4:0]  report_row;
        logic [6:0]  report_col;
        logic [10:0] cursor_pos;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
    } result_t;

    // screen memory port control
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_ctrl_t;

    // request to the shared position unit
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } addr_req_t;

endpackage

@@ rtl/ttc_screen_ram.sv @@
// screen cell store, one write port and one registered read port
module ttc_screen_ram
    import ttc_pkg::*;
(
    input  logic              clk,
    input  ram_ctrl_t         ctrl,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem_reg [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem_reg[ctrl.waddr] <= ctrl.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.re)
        begin
            rdata_reg <= mem_reg[ctrl.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ttc_addr_unit.sv @@
// shared row times columns plus column unit with registered result
module ttc_addr_unit
    import ttc_pkg::*;
(
    input  logic              clk,
    input  addr_req_t         req,
    output logic [ADDR_W-1:0] pos
);

    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;

    assign pos_next = ADDR_W'(req.row) * ADDR_W'(COLS) + ADDR_W'(req.col);

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

@@ rtl/ttc_seq.sv @@
// sequencer: cursor, attribute, operation decode and memory sweeps
module ttc_seq
    import ttc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  item_t             in_item,
    output logic              in_ready,
    input  logic              out_free,
    output logic              res_load,
    output result_t           res,
    output ram_ctrl_t         ram_ctrl,
    input  logic [CELL_W-1:0] ram_rdata,
    output addr_req_t         addr_req,
    input  logic [ADDR_W-1:0] addr_pos
);

    localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(CELLS - COLS);
    localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLS - 1);
    localparam logic [CELL_W-1:0] BLANK_DEF  = {DEF_ATTR_B, CH_SPACE};

    state_t state_reg, state_next;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [7:0]        cur_attr_reg, cur_attr_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;

    logic [2:0] func_reg;
    logic [7:0] char_reg;
    logic [7:0] row_sel_reg;
    logic [7:0] col_sel_reg;
    logic [7:0] attr_reg;
    logic       inside_reg;

    logic accept;
    logic is_nl, is_cr, is_bs, is_plain;
    logic adv_line, scroll_req;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // put-character decode on the held word
    assign is_nl    = (char_reg == CH_NEWLINE);
    assign is_cr    = (char_reg == CH_RETURN);
    assign is_bs    = (char_reg == CH_BACKSPACE);
    assign is_plain = !is_nl && !is_cr && !is_bs;
    assign adv_line = (func_reg == FN_PUT) && (is_nl || (is_plain && col_reg == COL_LAST));
    assign scroll_req = adv_line && (row_reg == ROW_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            cur_attr_reg <= DEF_ATTR_B;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            cur_attr_reg <= cur_attr_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= in_item.func;
            char_reg    <= in_item.char_code;
            row_sel_reg <= in_item.row_sel;
            col_sel_reg <= in_item.col_sel;
            attr_reg    <= in_item.attr;
            inside_reg  <= (in_item.row_sel < ROWS_B) && (in_item.col_sel < COLS_B);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (func_reg == FN_CLEAR)
                begin
                    state_next = ST_CLEAR;
                end
                else if (scroll_req)
                begin
                    state_next = ST_SCROLL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCROLL:
            begin
                if (cnt_reg == SCROLL_END)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK, ST_CLEAR:
            begin
                if (cnt_reg == CELL_LAST)
                begin
                    state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        cur_attr_next = cur_attr_reg;
        cnt_next      = cnt_reg;
        ram_ctrl      = '0;
        addr_req      = '0;
        res_load      = 1'b0;

        res.report_row = 5'(row_reg);
        res.report_col = 7'(col_reg);
        res.cursor_pos = 11'(addr_pos);
        res.read_char  = '0;
        res.read_attr  = '0;
        if ((func_reg == FN_READ) && inside_reg)
        begin
            res.read_char = ram_rdata[7:0];
            res.read_attr = ram_rdata[15:8];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // cell address of the coming operation
                addr_req.en = accept;
                if (in_item.func == FN_PUT)
                begin
                    addr_req.row = row_reg;
                    addr_req.col = col_reg;
                    if ((in_item.char_code == CH_BACKSPACE) && (col_reg != '0))
                    begin
                        addr_req.col = col_reg - 1'b1;
                    end
                end
                else
                begin
                    addr_req.row = in_item.row_sel[ROW_W-1:0];
                    addr_req.col = in_item.col_sel[COL_W-1:0];
                end
            end
            ST_EXEC:
            begin
                cnt_next = '0;
                unique case (func_reg)
                    FN_PUT:
                    begin
                        if (is_cr)
                        begin
                            col_next = '0;
                        end
                        else if (is_bs)
                        begin
                            if (col_reg != '0)
                            begin
                                col_next       = col_reg - 1'b1;
                                ram_ctrl.we    = 1'b1;
                                ram_ctrl.waddr = addr_pos;
                                ram_ctrl.wdata = {cur_attr_reg, CH_SPACE};
                            end
                        end
                        else if (is_plain)
                        begin
                            ram_ctrl.we    = 1'b1;
                            ram_ctrl.waddr = addr_pos;
                            ram_ctrl.wdata = {cur_attr_reg, char_reg};
                            col_next       = col_reg + 1'b1;
                        end
                        if (adv_line)
                        begin
                            col_next = '0;
                            if (row_reg != ROW_LAST)
                            begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                    end
                    FN_WRITE:
                    begin
                        ram_ctrl.we    = inside_reg;
                        ram_ctrl.waddr = addr_pos;
                        ram_ctrl.wdata = {attr_reg, char_reg};
                    end
                    FN_SETCUR:
                    begin
                        row_next = (row_sel_reg >= ROWS_B) ? ROW_LAST : row_sel_reg[ROW_W-1:0];
                        col_next = (col_sel_reg >= COLS_B) ? COL_LAST : col_sel_reg[COL_W-1:0];
                    end
                    FN_CLEAR:
                    begin
                        row_next      = '0;
                        col_next      = '0;
                        cur_attr_next = DEF_ATTR_B;
                    end
                    FN_ATTR:
                    begin
                        cur_attr_next = attr_reg;
                    end
                    FN_READ:
                    begin
                        ram_ctrl.re    = inside_reg;
                        ram_ctrl.raddr = addr_pos;
                    end
                    default:
                    begin
                    end
                endcase
                // cursor position for the result, from the updated cursor
                addr_req.en  = 1'b1;
                addr_req.row = row_next;
                addr_req.col = col_next;
            end
            ST_SCROLL:
            begin
                // read a line below, write the cell fetched in the previous cycle
                ram_ctrl.re    = (cnt_reg != SCROLL_END);
                ram_ctrl.raddr = ADDR_W'(cnt_reg + ADDR_W'(COLS));
                ram_ctrl.we    = (cnt_reg != '0);
                ram_ctrl.waddr = cnt_reg - 1'b1;
                ram_ctrl.wdata = ram_rdata;
                if (cnt_reg != SCROLL_END)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_BLANK, ST_CLEAR:
            begin
                ram_ctrl.we    = 1'b1;
                ram_ctrl.waddr = cnt_reg;
                ram_ctrl.wdata = BLANK_DEF;
                if (cnt_reg != CELL_LAST)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_POS:
            begin
                addr_req.en  = 1'b1;
                addr_req.row = row_reg;
                addr_req.col = col_reg;
            end
            ST_FINISH:
            begin
                res_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/text_terminal_cursor_engine_top.sv @@
// top level of the character-cell text terminal cursor engine
// the result word passes the EXEC and FINISH states and then the output register, for every
//   operation that neither clears nor scrolls; a new word is taken only after the last one's result is loaded
// a clear writes every cell, and a scroll copies the screen up a line and blanks the last line,
//   through the single write port of the screen memory, one cell per cycle
// reset: cursor home, attribute fifteen, output empty; screen cells hold no
//   defined value until a clear, and no clearing pass runs after reset
module text_terminal_cursor_engine_top
    import ttc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input word stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // char_code, row_sel, col_sel, attr
    input  logic [2:0]  s_tuser,    // func
    // result word stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // report_row, report_col, cursor_pos, read_char,
                                    // read_attr, zero fill
);

    item_t             in_item;
    result_t           res;
    logic              res_load;
    logic              out_free;
    ram_ctrl_t         ram_ctrl;
    logic [CELL_W-1:0] ram_rdata;
    addr_req_t         addr_req;
    logic [ADDR_W-1:0] addr_pos;

    logic              m_tvalid_reg, m_tvalid_next;
    result_t           m_res_reg;

    // unpack the input word, lowest field first
    assign in_item.func      = s_tuser;
    assign in_item.char_code = s_tdata[7:0];
    assign in_item.row_sel   = s_tdata[15:8];
    assign in_item.col_sel   = s_tdata[23:16];
    assign in_item.attr      = s_tdata[31:24];

    // output register frees when empty or when its word is taken
    assign out_free = !m_tvalid_reg || m_tready;

    ttc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res),
        .ram_ctrl  (ram_ctrl),
        .ram_rdata (ram_rdata),
        .addr_req  (addr_req),
        .addr_pos  (addr_pos)
    );

    // the one multiplier: cell addresses and the reported cursor position
    ttc_addr_unit u_addr (
        .clk (clk),
        .req (addr_req),
        .pos (addr_pos)
    );

    // character in the low byte, attribute in the high byte
    ttc_screen_ram u_ram (
        .clk   (clk),
        .ctrl  (ram_ctrl),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_res_reg.read_attr, m_res_reg.read_char,
                       m_res_reg.cursor_pos, m_res_reg.report_col, m_res_reg.report_row};

endmodule

@@ tb/tb.sv @@
// testbench of the text terminal cursor engine: a directed table and random commands,
// each result word checked against a typed answer or a console predictor
module tb
    import ttc_pkg::*;
();

    // spare operation codes, the block answers them with the cursor only
    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;

    localparam int RANDOM_WORDS = 650;
    localparam int PHASE_WORDS  = RANDOM_WORDS / 3;
    // sized for the slowest case: every word scrolls, plus long stalls
    localparam int CYCLE_LIMIT  = 4_000_000;
    // wait past the last result to catch stray words
    localparam int DRAIN_CYCLES = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    // one row of the directed table: command, whether the answer is typed in, the answer
    typedef struct packed {
        item_t   w;
        logic    typed;
        result_t want;
    } dir_row_t;

    dir_row_t directed_table [$];
    result_t  expected_reports [$];

    // console state as the predictor sees it
    logic [15:0] shadow_screen [CELLS];
    logic [4:0]  shadow_row;
    logic [6:0]  shadow_col;
    logic [7:0]  shadow_attr;

    int fail_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;

    text_terminal_cursor_engine_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------------------

    // column 0 of the next row; at the bottom the screen moves up and the last line blanks
    task automatic shadow_next_line();
        int i;
        shadow_col = '0;
        if (shadow_row == 5'(ROWS - 1))
        begin
            for (i = 0; i < CELLS - COLS; i++)
                shadow_screen[ADDR_W'(i)] = shadow_screen[ADDR_W'(i + COLS)];
            for (i = CELLS - COLS; i < CELLS; i++)
                shadow_screen[ADDR_W'(i)] = {DEF_ATTR_B, CH_SPACE};
        end
        else
            shadow_row = shadow_row + 5'd1;
    endtask

    task automatic shadow_put(input logic [7:0] ch);
        int here;
        here = shadow_row * COLS + shadow_col;
        if (ch == CH_NEWLINE)
            shadow_next_line();
        else if (ch == CH_RETURN)
            shadow_col = '0;
        else if (ch == CH_BACKSPACE)
        begin
            // nothing happens at column zero
            if (shadow_col != '0)
            begin
                shadow_col = shadow_col - 7'd1;
                shadow_screen[ADDR_W'(here - 1)] = {shadow_attr, CH_SPACE};
            end
        end
        else
        begin
            shadow_screen[ADDR_W'(here)] = {shadow_attr, ch};
            if (shadow_col == 7'(COLS - 1))
                shadow_next_line();
            else
                shadow_col = shadow_col + 7'd1;
        end
    endtask

    // applies one command to the shadow console and returns the report it causes
    task automatic console_predict(input item_t w, output result_t r);
        logic        on_screen;
        logic [15:0] cell_word;
        int          i;
        on_screen = (w.row_sel < ROWS_B) && (w.col_sel < COLS_B);
        r = '0;
        case (w.func)
            FN_PUT:
                shadow_put(w.char_code);
            FN_WRITE:
                if (on_screen)
                    shadow_screen[ADDR_W'(w.row_sel * COLS + w.col_sel)] =
                        {w.attr, w.char_code};
            FN_SETCUR:
            begin
                shadow_row = (w.row_sel >= ROWS_B) ? 5'(ROWS - 1) : w.row_sel[4:0];
                shadow_col = (w.col_sel >= COLS_B) ? 7'(COLS - 1) : w.col_sel[6:0];
            end
            FN_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    shadow_screen[ADDR_W'(i)] = {DEF_ATTR_B, CH_SPACE};
                shadow_row  = '0;
                shadow_col  = '0;
                shadow_attr = DEF_ATTR_B;
            end
            FN_ATTR:
                shadow_attr = w.attr;
            FN_READ:
                if (on_screen)
                begin
                    cell_word = shadow_screen[ADDR_W'(w.row_sel * COLS + w.col_sel)];
                    r.read_char = cell_word[7:0];
                    r.read_attr = cell_word[15:8];
                end
            default:
                ;
        endcase
        r.report_row = shadow_row;
        r.report_col = shadow_col;
        r.cursor_pos = 11'(shadow_row * COLS + shadow_col);
    endtask

    // ---------------------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------------------

    task automatic dir_row(input logic [2:0] f, input logic [7:0] ch, input logic [7:0] row,
                           input logic [7:0] col, input logic [7:0] at, input logic typed,
                           input logic [4:0] er, input logic [6:0] ec, input logic [10:0] ep,
                           input logic [7:0] erc, input logic [7:0] era);
        dir_row_t d;
        d.w     = '{func: f, char_code: ch, row_sel: row, col_sel: col, attr: at};
        d.typed = typed;
        d.want  = '{report_row: er, report_col: ec, cursor_pos: ep,
                    read_char: erc, read_attr: era};
        directed_table.push_back(d);
    endtask

    // mostly well-formed console traffic, some out-of-range and spare codes
    function automatic item_t random_command();
        item_t w;
        int    pick;
        w.func      = FN_PUT;
        w.char_code = 8'($urandom_range(255));
        w.row_sel   = 8'($urandom_range(255));
        w.col_sel   = 8'($urandom_range(255));
        w.attr      = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            w.func = FN_PUT;
            case ($urandom_range(19))
                0, 1:    w.char_code = CH_NEWLINE;
                2, 3:    w.char_code = CH_BACKSPACE;
                4:       w.char_code = CH_RETURN;
                default: ;
            endcase
        end
        else if (pick < 55)
        begin
            w.func = FN_WRITE;
            if ($urandom_range(4) != 0)
            begin
                w.row_sel = 8'($urandom_range(ROWS - 1));
                w.col_sel = 8'($urandom_range(COLS - 1));
            end
        end
        else if (pick < 65)
        begin
            w.func = FN_SETCUR;
            // lean toward the bottom rows so that scrolling happens often
            if ($urandom_range(3) != 0)
            begin
                w.row_sel = $urandom_range(1) ? 8'(ROWS - 1) : 8'($urandom_range(ROWS - 1));
                w.col_sel = 8'($urandom_range(COLS - 1));
            end
        end
        else if (pick < 66)
            w.func = FN_CLEAR;
        else if (pick < 74)
            w.func = FN_ATTR;
        else if (pick < 96)
        begin
            w.func = FN_READ;
            if ($urandom_range(6) != 0)
            begin
                w.row_sel = 8'($urandom_range(ROWS - 1));
                w.col_sel = 8'($urandom_range(COLS - 1));
            end
        end
        else
            w.func = $urandom_range(1) ? FN_SPARE6 : FN_SPARE7;
        return w;
    endfunction

    // offers one word, waits for the handshake, then books the report it should cause
    task automatic send_word(input item_t w, input logic typed, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.attr, w.col_sel, w.row_sel, w.char_code};
        s_tuser  <= w.func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        console_predict(w, predicted);
        expected_reports.push_back(typed ? want : predicted);
    endtask

    // receiver side: random back-pressure at the current rate
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // ---------------------------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------------------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result word fields from bit 0 up: report_row, report_col, cursor_pos,
    // read_char, read_attr
    always @(posedge clk)
    begin : report_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("result word with no report expected: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("report_row", int'(want.report_row), int'(m_tdata[4:0]));
                check_field("report_col", int'(want.report_col), int'(m_tdata[11:5]));
                check_field("cursor_pos", int'(want.cursor_pos), int'(m_tdata[22:12]));
                check_field("read_char", int'(want.read_char), int'(m_tdata[30:23]));
                check_field("read_attr", int'(want.read_attr), int'(m_tdata[38:31]));
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------------------

    initial
    begin : main_flow
        int k;
        fail_count    = 0;
        send_idle_pct = 26;
        recv_idle_pct = 57;
        shadow_row    = '0;
        shadow_col    = '0;
        shadow_attr   = DEF_ATTR_B;
        for (k = 0; k < CELLS; k++)
            shadow_screen[ADDR_W'(k)] = '0;

        // func       char          row    col    attr   typed  row    col    pos
        //   rch    rat
        // state right after reset, then attribute zero for the next writes
        dir_row(FN_ATTR,   8'h00,        8'd0,  8'd0,  8'h00, 1'b1, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_PUT,    8'h41,        8'd0,  8'd0,  8'h00, 1'b1, 5'd0,  7'd1,  11'd1,
                8'h00, 8'h00);
        dir_row(FN_PUT,    CH_BACKSPACE, 8'd0,  8'd0,  8'h00, 1'b1, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        // backspace at column zero leaves everything as it is
        dir_row(FN_PUT,    CH_BACKSPACE, 8'd0,  8'd0,  8'h00, 1'b1, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_SPARE6, 8'h00,        8'd0,  8'd0,  8'h00, 1'b1, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_SPARE7, 8'hFF,        8'hFF, 8'hFF, 8'hFF, 1'b1, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        // cursor set clamps to the bottom right corner
        dir_row(FN_SETCUR, 8'h00,        8'hFF, 8'hFF, 8'h00, 1'b1, 5'd24, 7'd79, 11'd1999,
                8'h00, 8'h00);
        // last cell: wrap and scroll
        dir_row(FN_PUT,    8'h5A,        8'd0,  8'd0,  8'h00, 1'b1, 5'd24, 7'd0,  11'd1920,
                8'h00, 8'h00);
        // writes off the screen are dropped
        dir_row(FN_WRITE,  8'hFF,        8'hFF, 8'd0,  8'hFF, 1'b1, 5'd24, 7'd0,  11'd1920,
                8'h00, 8'h00);
        dir_row(FN_WRITE,  8'hFF,        8'd0,  8'hFF, 8'hFF, 1'b1, 5'd24, 7'd0,  11'd1920,
                8'h00, 8'h00);
        // clear defines every cell before any read
        dir_row(FN_CLEAR,  8'h00,        8'd0,  8'd0,  8'h00, 1'b1, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_READ,   8'h00,        8'd0,  8'd0,  8'h00, 1'b1, 5'd0,  7'd0,  11'd0,
                CH_SPACE, DEF_ATTR_B);
        // reads off the screen answer zero
        dir_row(FN_READ,   8'h00,        8'd25, 8'd0,  8'h00, 1'b1, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_READ,   8'h00,        8'd0,  8'd80, 8'h00, 1'b1, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_READ,   8'h00,        8'hFF, 8'hFF, 8'h00, 1'b1, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_WRITE,  8'hFF,        8'd24, 8'd79, 8'hFF, 1'b1, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_READ,   8'h00,        8'd24, 8'd79, 8'h00, 1'b1, 5'd0,  7'd0,  11'd0,
                8'hFF, 8'hFF);
        // from here on the predictor answers
        dir_row(FN_ATTR,   8'h00,        8'd0,  8'd0,  8'hAA, 1'b0, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_PUT,    8'h00,        8'd0,  8'd0,  8'h00, 1'b0, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_PUT,    8'hFF,        8'd0,  8'd0,  8'h00, 1'b0, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_PUT,    CH_RETURN,    8'd0,  8'd0,  8'h00, 1'b0, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_PUT,    CH_NEWLINE,   8'd0,  8'd0,  8'h00, 1'b0, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        // newline on the last row scrolls the corner cell up one line
        dir_row(FN_SETCUR, 8'h00,        8'd24, 8'd5,  8'h00, 1'b0, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_PUT,    CH_NEWLINE,   8'd0,  8'd0,  8'h00, 1'b0, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_READ,   8'h00,        8'd23, 8'd79, 8'h00, 1'b0, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);
        dir_row(FN_READ,   8'h00,        8'd24, 8'd0,  8'h00, 1'b0, 5'd0,  7'd0,  11'd0,
                8'h00, 8'h00);

        // reset held low, then released on a rising edge
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[i])
            send_word(directed_table[i].w, directed_table[i].typed, directed_table[i].want);

        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            // idling phases: sender light and receiver heavy, then swapped, then none
            if (k == PHASE_WORDS)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 26;
            end
            else if (k == 2 * PHASE_WORDS)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_word(random_command(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
